### rtl/baseline_tracking_force_trigger_top_defines.svh
// ----------------------------------------------------------------------------
// Baseline tracking force trigger - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef BASELINE_TRACKING_FORCE_TRIGGER_TOP_DEFINES_SVH
`define BASELINE_TRACKING_FORCE_TRIGGER_TOP_DEFINES_SVH

// Same-cycle implication.
`define BTFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/btft_pkg.sv
// ----------------------------------------------------------------------------
// Baseline tracking force trigger - package
// Fixed widths, register reset values and register indexes.
// ----------------------------------------------------------------------------
package btft_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int THRESH_W   = 24;
  localparam int RUN_W      = 8;

  localparam logic [RUN_W-1:0]    RUN_MAX     = '1;
  localparam logic [THRESH_W-1:0] THRESH_RST  = 24'd1000;
  localparam logic [RUN_W-1:0]    CONFIRM_RST = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_CONFIRM   = 2'd1
  } cfg_reg_t;

endpackage

### rtl/baseline_tracking_force_trigger_top.sv
// ----------------------------------------------------------------------------
// Baseline tracking force trigger - top level
// Load-cell press detector against a trimmed-mean running baseline.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one converter sample per beat (in_valid / in_stall). Zero is a
//            failed read and only produces an "ignored" result.
//   out_*  : exactly one result beat per sample (out_valid / out_stall):
//            trigger, deviation, baseline after the step, baseline_updated,
//            sample_ignored.
//   cfg_*  : register writes (index 0 threshold, 1 confirm count); cfg_ready
//            is always high, unknown indexes are dropped. Write only when idle.
// Path: a sample goes from the input register into the result register, where
//   the receiver takes it. Throughput: 1 sample per cycle unless stalled.
//   The sample register feeds one pass of logic (deviation compare, window
//   update, trimmed sum times a constant reciprocal for the divide by
//   WINDOW_SIZE-2) into the result register.
// Reset (rst_n low, synchronous): pipeline empties, baseline unloaded,
//   window cleared, threshold 1000, confirm count 2.
// Stall: a stalled result holds; one more sample waits in the input
//   register, then in_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`include "baseline_tracking_force_trigger_top_defines.svh"

module baseline_tracking_force_trigger_top
  import btft_pkg::*;
#(
  parameter int WINDOW_SIZE = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // sample channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_trigger,
  output logic [SAMPLE_BITS-1:0] out_deviation,
  output logic [SAMPLE_BITS-1:0] out_baseline,
  output logic                   out_baseline_updated,
  output logic                   out_sample_ignored,
  // register write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Window sum holds WINDOW_SIZE samples.
  localparam int SUM_W    = SAMPLE_BITS + $clog2(WINDOW_SIZE);
  localparam int CNT_W    = $clog2(WINDOW_SIZE);
  localparam int DIV      = WINDOW_SIZE - 2;
  localparam int DIV_L    = $clog2(DIV);
  // q = (n * ceil(2^(SUM_W+L) / DIV)) >> (SUM_W+L) is exact for n < 2^SUM_W.
  localparam int RECIP_SH = SUM_W + DIV_L;
  localparam int REC_W    = SUM_W + 1;
  localparam int PROD_W   = SUM_W + REC_W;
  localparam logic [REC_W-1:0] RECIP =
    REC_W'(((64'd1 << RECIP_SH) + 64'(DIV - 1)) / 64'(DIV));
  localparam int CMP_W    = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_SIZE - 1);

  // config registers
  logic [THRESH_W-1:0]    thresh_r;
  logic [RUN_W-1:0]       confirm_r;

  // input register
  logic                   in_vld_r;
  logic [SAMPLE_BITS-1:0] in_sample_r;

  // tracking state
  logic [SAMPLE_BITS-1:0] base_r,        base_nxt;
  logic                   base_loaded_r, base_loaded_nxt;
  logic [CNT_W-1:0]       win_cnt_r,     win_cnt_nxt;
  logic [SUM_W-1:0]       win_sum_r,     win_sum_nxt;
  logic [SAMPLE_BITS-1:0] win_max_r,     win_max_nxt;
  logic [SAMPLE_BITS-1:0] win_min_r,     win_min_nxt;
  logic [RUN_W-1:0]       run_cnt_r,     run_cnt_nxt;

  // result register
  logic                   out_vld_r;
  logic                   trig_r,        trig_nxt;
  logic [SAMPLE_BITS-1:0] dev_r,         dev_nxt;
  logic                   upd_r,         upd_nxt;
  logic                   ign_r,         ign_nxt;

  // datapath
  logic                   adv;
  logic [SAMPLE_BITS-1:0] dev_abs;
  logic                   over;
  logic [SUM_W-1:0]       sum_add;
  logic [SAMPLE_BITS-1:0] max_add;
  logic [SAMPLE_BITS-1:0] min_add;
  logic [SUM_W-1:0]       trimmed;
  logic [PROD_W-1:0]      product;
  logic [SAMPLE_BITS-1:0] quot;
  logic [RUN_W-1:0]       run_inc;

  // Sample register moves into the result register when that is free or
  // being drained this cycle.
  assign adv       = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && out_vld_r && out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    dev_abs = (in_sample_r > base_r) ? (in_sample_r - base_r) : (base_r - in_sample_r);
    over    = CMP_W'(dev_abs) > CMP_W'(thresh_r);
    sum_add = win_sum_r + SUM_W'(in_sample_r);
    max_add = (in_sample_r > win_max_r) ? in_sample_r : win_max_r;
    min_add = (in_sample_r < win_min_r) ? in_sample_r : win_min_r;
    // true extremes of the completed window
    trimmed = sum_add - SUM_W'(max_add) - SUM_W'(min_add);
    product = PROD_W'(trimmed) * PROD_W'(RECIP);
    quot    = product[RECIP_SH +: SAMPLE_BITS];
    run_inc = run_cnt_r + RUN_W'(1);
  end

  always_comb begin
    base_nxt        = base_r;
    base_loaded_nxt = base_loaded_r;
    win_cnt_nxt     = win_cnt_r;
    win_sum_nxt     = win_sum_r;
    win_max_nxt     = win_max_r;
    win_min_nxt     = win_min_r;
    run_cnt_nxt     = run_cnt_r;
    trig_nxt        = 1'b0;
    dev_nxt         = '0;
    upd_nxt         = 1'b0;
    ign_nxt         = 1'b0;
    if (in_sample_r == '0) begin
      ign_nxt = 1'b1;
    end else if (!base_loaded_r) begin
      base_nxt        = in_sample_r;
      base_loaded_nxt = 1'b1;
    end else begin
      dev_nxt = dev_abs;
      if (over) begin
        if (run_cnt_r != RUN_MAX) begin
          run_cnt_nxt = run_inc;
          trig_nxt    = (run_inc == confirm_r);
        end
        // press in progress: drop the partial window
        win_cnt_nxt = '0;
        win_sum_nxt = '0;
        win_max_nxt = '0;
        win_min_nxt = '1;
      end else begin
        run_cnt_nxt = '0;
        if (win_cnt_r == CNT_LAST) begin
          base_nxt    = quot;
          upd_nxt     = 1'b1;
          win_cnt_nxt = '0;
          win_sum_nxt = '0;
          win_max_nxt = '0;
          win_min_nxt = '1;
        end else begin
          win_cnt_nxt = win_cnt_r + CNT_W'(1);
          win_sum_nxt = sum_add;
          win_max_nxt = max_add;
          win_min_nxt = min_add;
        end
      end
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESH_RST;
      confirm_r <= CONFIRM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: thresh_r  <= cfg_wdata[THRESH_W-1:0];
        REG_CONFIRM:   confirm_r <= cfg_wdata[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_sample_r <= in_sample;
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r        <= '0;
      base_loaded_r <= 1'b0;
      win_cnt_r     <= '0;
      win_sum_r     <= '0;
      win_max_r     <= '0;
      win_min_r     <= '1;
      run_cnt_r     <= '0;
    end else if (adv) begin
      base_r        <= base_nxt;
      base_loaded_r <= base_loaded_nxt;
      win_cnt_r     <= win_cnt_nxt;
      win_sum_r     <= win_sum_nxt;
      win_max_r     <= win_max_nxt;
      win_min_r     <= win_min_nxt;
      run_cnt_r     <= run_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trig_r <= trig_nxt;
      dev_r  <= dev_nxt;
      upd_r  <= upd_nxt;
      ign_r  <= ign_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_trigger          = trig_r;
  assign out_deviation        = dev_r;
  assign out_baseline         = base_r;
  assign out_baseline_updated = upd_r;
  assign out_sample_ignored   = ign_r;

  // checks
  `BTFT_ASSERT_NOW(a_ign_quiet, clk, rst_n, out_valid && out_sample_ignored,
    !out_trigger && !out_baseline_updated && (out_deviation == '0),
    "ignored sample produced activity")
  `BTFT_ASSERT_NOW(a_trig_xor_upd, clk, rst_n, out_valid,
    !(out_trigger && out_baseline_updated),
    "trigger and baseline update in one beat")
  `BTFT_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall,
    out_valid && out_stall,
    "input stalled without a stalled result")
  `BTFT_ASSERT_NEXT(a_upd_clears, clk, rst_n, adv && upd_nxt,
    (win_cnt_r == '0) && (win_sum_r == '0),
    "window not cleared after baseline update")

endmodule
